### design/sobel_edge_magnitude_rgb_core_macros.svh
// Assertion macros for the Sobel edge magnitude core.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SEM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SEM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sem_pkg.sv
// Types and constants shared by the Sobel edge magnitude core.
// No dependencies.
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int NUM_CH        = 3;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Channel 0 is blue, 1 green, 2 red.
    typedef logic [NUM_CH-1:0][7:0] rgb_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] edge_blue;
        logic [7:0] edge_green;
        logic [7:0] edge_red;
        logic       last_of_frame;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SQ,
        S_ROOT,
        S_DONE
    } state_t;

endpackage

### design/sobel_edge_magnitude_rgb_core.sv
// Sobel 3x3 edge magnitude over an RGB raster stream, top level.
// Depends on sem_pkg and sobel_edge_magnitude_rgb_core_macros.svh.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (kind, in_blue, in_green, in_red)
//  out     | output    | out_valid/out_stall| out_data (edge_*, last_of_frame)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// An item that produces a result passes through the line store read, the window
// cycle, the squaring cycle, the bit-serial rounded root and the load of the output
// register, which waits while the output stalls. An item without result ends after its window cycle.
// Reset clears counters, window and handshake state; the line stores need no clearing.
// A stalled output holds the finished result while the next item is already accepted.
module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [12:0] cfg_data
);

`include "sobel_edge_magnitude_rgb_core_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH = 13'(HEIGHT_LIMIT);

    state_t state_reg, state_next;

    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [12:0] in_row_reg, in_row_next;
    logic [11:0] out_row_reg, out_row_next;

    rgb_t upper_mem [MAX_WIDTH];
    rgb_t lower_mem [MAX_WIDTH];
    rgb_t up_rd_reg, lo_rd_reg, px_reg;
    rgb_t win_reg [3][3];
    rgb_t win_next [3][3];
    rgb_t tap [3][3];

    logic signed [10:0] gx_reg [NUM_CH];
    logic signed [10:0] gy_reg [NUM_CH];
    logic signed [10:0] gx_c [NUM_CH];
    logic signed [10:0] gy_c [NUM_CH];
    logic [20:0] sq_reg [NUM_CH];
    logic [7:0]  lo_reg [NUM_CH];
    logic [7:0]  lo_next [NUM_CH];
    logic [7:0]  bit_reg;
    logic        last_reg;

    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic [12:0] w_eff, h_eff;
    logic        accept, emit, is_last, col_wrap, ocol_wrap, out_free;
    logic        mask_top, mask_bot, mask_lft, mask_rgt;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        w_eff = {2'b0, frame_width_reg};
        if (frame_width_reg == 11'd0)
            w_eff = 13'd1;
        else if (w_eff > MAXW)
            w_eff = MAXW;
        h_eff = frame_height_reg;
        if (frame_height_reg == 13'd0)
            h_eff = 13'd1;
        else if (h_eff > MAXH)
            h_eff = MAXH;
    end

    assign emit      = (in_row_reg >= 13'd2) || (in_row_reg == 13'd1 && in_col_reg != '0);
    assign col_wrap  = (13'(in_col_reg) + 13'd1) >= w_eff;
    assign ocol_wrap = (13'(out_col_reg) + 13'd1) >= w_eff;
    assign mask_top  = out_row_reg == 12'd0;
    assign mask_bot  = (13'(out_row_reg) + 13'd1) >= h_eff;
    assign mask_lft  = out_col_reg == '0;
    assign mask_rgt  = ocol_wrap;
    assign is_last   = mask_bot && ocol_wrap;

    // Window shift and tap selection. At column zero the center is the last
    // pixel of the previous row, so the taps come from the window before the shift.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_rd_reg;
        win_next[1][2] = lo_rd_reg;
        win_next[2][2] = px_reg;
        for (int r = 0; r < 3; r++)
        begin
            if (in_col_reg == '0)
            begin
                tap[r][0] = win_reg[r][1];
                tap[r][1] = win_reg[r][2];
                tap[r][2] = '0;
            end
            else
            begin
                tap[r][0] = win_next[r][0];
                tap[r][1] = win_next[r][1];
                tap[r][2] = win_next[r][2];
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && mask_top) || (r == 2 && mask_bot) ||
                    (c == 0 && mask_lft) || (c == 2 && mask_rgt))
                    tap[r][c] = '0;
            end
        end
    end

    always_comb
    begin
        logic [9:0] xp, xn, yp, yn;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            xp = 10'(tap[0][2][ch]) + {1'b0, tap[1][2][ch], 1'b0} + 10'(tap[2][2][ch]);
            xn = 10'(tap[0][0][ch]) + {1'b0, tap[1][0][ch], 1'b0} + 10'(tap[2][0][ch]);
            yp = 10'(tap[2][0][ch]) + {1'b0, tap[2][1][ch], 1'b0} + 10'(tap[2][2][ch]);
            yn = 10'(tap[0][0][ch]) + {1'b0, tap[0][1][ch], 1'b0} + 10'(tap[0][2][ch]);
            gx_c[ch] = $signed({1'b0, xp}) - $signed({1'b0, xn});
            gy_c[ch] = $signed({1'b0, yp}) - $signed({1'b0, yn});
        end
    end

    // One step of the rounded root: keep the bit if k*k-k is still below the sum.
    always_comb
    begin
        logic [7:0]  k;
        logic [15:0] kk;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            k  = lo_reg[ch] | bit_reg;
            kk = 16'(k) * 16'(k) - 16'(k);
            lo_next[ch] = ({5'b0, kk} < sq_reg[ch]) ? k : lo_reg[ch];
        end
    end

    // Counter update for the item in the window cycle; a configuration write restarts all counters.
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (state_reg == S_CALC)
        begin
            if (emit && is_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 13'd1;
                end
                else
                    in_col_next = in_col_reg + CW'(1);
                if (emit)
                begin
                    if (ocol_wrap)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 12'd1;
                    end
                    else
                        out_col_next = out_col_reg + CW'(1);
                end
            end
        end
        if (cfg_we)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_CALC;
            S_CALC: state_next = emit ? S_SQ : S_IDLE;
            S_SQ:   state_next = S_ROOT;
            S_ROOT: if (bit_reg[0]) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            bit_reg          <= '0;
            out_valid_reg    <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_CALC)
                win_reg <= win_next;
            if (state_reg == S_SQ)
                bit_reg <= 8'h80;
            else if (state_reg == S_ROOT)
                bit_reg <= bit_reg >> 1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Line stores: read on acceptance, written back in the window cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg <= upper_mem[in_col_reg];
            lo_rd_reg <= lower_mem[in_col_reg];
            px_reg    <= (in_data.kind == KIND_FLUSH) ? rgb_t'(0)
                       : {in_data.in_red, in_data.in_green, in_data.in_blue};
        end
        if (state_reg == S_CALC)
        begin
            upper_mem[in_col_reg] <= lo_rd_reg;
            lower_mem[in_col_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            gx_reg   <= gx_c;
            gy_reg   <= gy_c;
            last_reg <= is_last;
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (state_reg == S_SQ)
            begin
                // The squares need the full 22-bit signed product.
                sq_reg[ch] <= 21'($unsigned(22'(gx_reg[ch] * gx_reg[ch])))
                            + 21'($unsigned(22'(gy_reg[ch] * gy_reg[ch])));
                lo_reg[ch] <= '0;
            end
            else if (state_reg == S_ROOT)
                lo_reg[ch] <= lo_next[ch];
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.edge_blue     <= lo_reg[0];
            out_data_reg.edge_green    <= lo_reg[1];
            out_data_reg.edge_red      <= lo_reg[2];
            out_data_reg.last_of_frame <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SEM_ASSERT_NXT(a_accept_to_calc, accept, state_reg == S_CALC, "accept must start window cycle")
    `SEM_ASSERT_NXT(a_last_restarts, state_reg == S_CALC && emit && is_last && !cfg_we,
        in_col_reg == '0 && in_row_reg == 13'd0 && out_row_reg == 12'd0, "frame end must restart")
    `SEM_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE,
        "result must come from done state")
    `SEM_ASSERT_IMP(a_root_bit, state_reg == S_ROOT, $onehot(bit_reg), "root step must be one-hot")

endmodule
